@@ rtl/core/edge_non_max_suppression_defines.svh @@
// edge_non_max_suppression_defines.svh: assertion macros shared by the rtl
// no dependencies; included by the modules that carry assertions
`ifndef EDGE_NON_MAX_SUPPRESSION_DEFINES_SVH
`define EDGE_NON_MAX_SUPPRESSION_DEFINES_SVH

// same-cycle implication check, disabled while reset is asserted
`define ENMS_ASSERT_IMPL(name, clk_s, rst_s, ante, cons) \
    name: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// next-cycle implication check, disabled while reset is asserted
`define ENMS_ASSERT_NEXT(name, clk_s, rst_s, ante, cons) \
    name: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

@@ rtl/core/enms_pkg.sv @@
// enms_pkg: constants, types and the angle quantizer for edge non-max suppression
// no dependencies; used by enms_if, enms_ctrl, enms_core and the top level
`default_nettype none

package enms_pkg;

    localparam int MAX_WIDTH_DEF = 1024;
    localparam int MAG_BITS_DEF  = 16;
    localparam int MAX_HEIGHT    = 1024;
    localparam int MIN_DIM       = 3;
    localparam int CFG_BITS      = 11;
    localparam int BORDER_BITS   = 4;
    localparam int ROW_BITS      = 10;
    localparam int CFG_IDX_BITS  = 2;
    localparam int ANG_BITS      = 13;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_BITS-1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_FRAME_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_BORDER_WIDTH = 2'd2;

    // angle bin limits in sixteenths of a degree
    localparam logic signed [ANG_BITS:0] ANG_HALF_TURN = 14'sd2880;
    localparam logic signed [ANG_BITS:0] ANG_B1        = 14'sd360;
    localparam logic signed [ANG_BITS:0] ANG_B2        = 14'sd1080;
    localparam logic signed [ANG_BITS:0] ANG_B3        = 14'sd1800;
    localparam logic signed [ANG_BITS:0] ANG_B4        = 14'sd2520;

    typedef enum logic [1:0] {
        SEC_HORIZ = 2'd0,
        SEC_DIAG  = 2'd1,
        SEC_VERT  = 2'd2,
        SEC_ANTI  = 2'd3
    } enms_sector_t;

    // per-pixel control decided when the transaction is taken
    typedef struct packed {
        logic started;
        logic border;
        logic last;
    } enms_flags_t;

    // fold the angle into [0,180) degrees and bin it into four directions
    function automatic enms_sector_t quantize_angle(input logic signed [ANG_BITS-1:0] angle);
        logic signed [ANG_BITS:0] a;
        enms_sector_t             sec;
        a = {angle[ANG_BITS-1], angle};
        if (a < 0)
        begin
            a = a + ANG_HALF_TURN;
        end
        if (a < 0)
        begin
            a = a + ANG_HALF_TURN;
        end
        if (a >= ANG_HALF_TURN)
        begin
            a = a - ANG_HALF_TURN;
        end
        if (a < ANG_B1)
        begin
            sec = SEC_HORIZ;
        end
        else if (a < ANG_B2)
        begin
            sec = SEC_DIAG;
        end
        else if (a < ANG_B3)
        begin
            sec = SEC_VERT;
        end
        else if (a < ANG_B4)
        begin
            sec = SEC_ANTI;
        end
        else
        begin
            sec = SEC_HORIZ;
        end
        return sec;
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/enms_if.sv @@
// enms_if: valid/ready channel interfaces for pixel and result transactions
// depends on enms_pkg
`default_nettype none

interface enms_pix_if #(parameter int MAG_BITS = enms_pkg::MAG_BITS_DEF);
    import enms_pkg::*;

    logic                       valid;
    logic                       ready;
    logic                       command;
    logic [MAG_BITS-1:0]        magnitude;
    logic signed [ANG_BITS-1:0] angle;

    modport source (output valid, command, magnitude, angle, input ready);
    modport sink   (input valid, command, magnitude, angle, output ready);
endinterface

interface enms_res_if #(parameter int MAG_BITS = enms_pkg::MAG_BITS_DEF);
    logic                valid;
    logic                ready;
    logic [MAG_BITS-1:0] edge_value;
    logic                suppressed;
    logic                last_of_frame;

    modport source (output valid, edge_value, suppressed, last_of_frame, input ready);
    modport sink   (input valid, edge_value, suppressed, last_of_frame, output ready);
endinterface

`default_nettype wire

@@ rtl/core/enms_ram.sv @@
// enms_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies
`default_nettype none

module enms_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/enms_div.sv @@
// enms_div: restoring divider, one quotient bit per cycle
// no dependencies; used by enms_ctrl to rebuild output coordinates
`default_nettype none

module enms_div #(
    parameter int NB = 22,
    parameter int DB = 11
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  wire logic [NB-1:0] dividend,
    input  wire logic [DB-1:0] divisor,
    output logic      [NB-1:0] quotient,
    output logic      [DB-1:0] remainder,
    output logic               busy,
    output logic               done
);

    localparam int CB = $clog2(NB + 1);

    logic [DB-1:0] rem_reg;
    logic [NB-1:0] quo_reg;
    logic [DB-1:0] dsr_reg;
    logic [CB-1:0] count_reg;
    logic          done_reg;
    logic [DB:0]   shifted;
    logic          fits;

    // trial subtract of the divisor from the shifted remainder
    assign shifted = {rem_reg, quo_reg[NB-1]};
    assign fits    = shifted >= {1'b0, dsr_reg};

    // iteration counter and completion pulse
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else if (start)
        begin
            count_reg <= CB'(NB);
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= count_reg == CB'(1);
            if (count_reg != '0)
            begin
                count_reg <= count_reg - CB'(1);
            end
        end
    end

    // remainder and quotient shift registers
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dsr_reg <= divisor;
        end
        else if (count_reg != '0)
        begin
            rem_reg <= fits ? DB'(shifted - {1'b0, dsr_reg}) : shifted[DB-1:0];
            quo_reg <= {quo_reg[NB-2:0], fits};
        end
    end

    assign quotient  = quo_reg;
    assign remainder = rem_reg;
    assign busy      = (count_reg != '0) || done_reg;
    assign done      = done_reg;

endmodule

`default_nettype wire

@@ rtl/core/enms_ctrl.sv @@
// enms_ctrl: configuration registers, raster counters and per-pixel control
// depends on enms_pkg, enms_div and edge_non_max_suppression_defines.svh
`default_nettype none
`include "edge_non_max_suppression_defines.svh"

module enms_ctrl #(
    parameter int MAX_WIDTH = enms_pkg::MAX_WIDTH_DEF
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_we,
    input  wire logic [enms_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  wire logic [enms_pkg::CFG_BITS-1:0]      cfg_data,
    input  wire logic                               in_valid,
    input  wire logic                               in_command,
    input  wire logic                               s2_free,
    output logic                                    in_ready,
    output logic                                    issue,
    output logic                                    drain,
    output logic [$clog2(MAX_WIDTH)-1:0]            addr,
    output enms_pkg::enms_flags_t                   flags
);
    import enms_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WB = $clog2(MAX_WIDTH + 1);
    localparam int TB = WB + CFG_BITS;
    localparam int XB = ((WB > BORDER_BITS) ? WB : BORDER_BITS) + 1;
    localparam int YB = TB + 1;

    logic [CFG_BITS-1:0]    frame_width_reg;
    logic [CFG_BITS-1:0]    frame_height_reg;
    logic [BORDER_BITS-1:0] border_width_reg;
    logic [TB-1:0]          total_reg;
    logic                   cfg_pend_reg;
    logic [CW-1:0]          column_reg, column_next;
    logic [ROW_BITS-1:0]    row_reg, row_next;
    logic [TB-1:0]          emit_reg, emit_next;
    logic [WB-1:0]          ox_reg, ox_next;
    logic [TB-1:0]          oy_reg, oy_next;

    logic [WB-1:0]          w_eff;
    logic [CFG_BITS-1:0]    h_eff;
    logic [BORDER_BITS-1:0] bw_eff;
    logic [CW-1:0]          col;
    logic                   accept;
    logic                   busy;
    logic                   div_busy;
    logic                   div_done;
    logic [TB-1:0]          div_quo;
    logic [WB-1:0]          div_rem;

    // clamp the configured geometry to the supported range
    always_comb
    begin
        if (32'(frame_width_reg) > MAX_WIDTH)
        begin
            w_eff = WB'(MAX_WIDTH);
        end
        else if (frame_width_reg < CFG_BITS'(MIN_DIM))
        begin
            w_eff = WB'(MIN_DIM);
        end
        else
        begin
            w_eff = WB'(frame_width_reg);
        end
        if (frame_height_reg > CFG_BITS'(MAX_HEIGHT))
        begin
            h_eff = CFG_BITS'(MAX_HEIGHT);
        end
        else if (frame_height_reg < CFG_BITS'(MIN_DIM))
        begin
            h_eff = CFG_BITS'(MIN_DIM);
        end
        else
        begin
            h_eff = frame_height_reg;
        end
        bw_eff = (border_width_reg == '0) ? BORDER_BITS'(1) : border_width_reg;
    end

    // rebuild the output column and row after a geometry change
    enms_div #(
        .NB (TB),
        .DB (WB)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cfg_pend_reg),
        .dividend  (emit_reg),
        .divisor   (w_eff),
        .quotient  (div_quo),
        .remainder (div_rem),
        .busy      (div_busy),
        .done      (div_done)
    );

    // handshake and the decisions taken with each transaction
    assign busy     = cfg_pend_reg || div_busy;
    assign drain    = emit_reg >= (total_reg - TB'(w_eff) - TB'(1));
    assign in_ready = !busy && !cfg_we && s2_free;
    assign accept   = in_valid && in_ready;
    assign issue    = accept && (drain || !in_command);
    assign col      = (WB'(column_reg) >= w_eff) ? CW'(w_eff - WB'(1)) : column_reg;
    assign addr     = col;

    always_comb
    begin
        flags.started = drain || (row_reg >= ROW_BITS'(2))
                        || ((row_reg == ROW_BITS'(1)) && (col != '0));
        flags.border  = (XB'(ox_reg) < XB'(bw_eff))
                        || ((XB'(ox_reg) + XB'(bw_eff)) >= XB'(w_eff))
                        || (YB'(oy_reg) < YB'(bw_eff))
                        || ((YB'(oy_reg) + YB'(bw_eff)) >= YB'(h_eff));
        flags.last    = emit_reg >= (total_reg - TB'(1));
    end

    // raster and output counters
    always_comb
    begin
        column_next = column_reg;
        row_next    = row_reg;
        emit_next   = emit_reg;
        ox_next     = ox_reg;
        oy_next     = oy_reg;
        if (div_done)
        begin
            ox_next = div_rem;
            oy_next = div_quo;
        end
        if (issue)
        begin
            if ((WB'(col) + WB'(1)) >= w_eff)
            begin
                column_next = '0;
                if (row_reg < ROW_BITS'(MAX_HEIGHT - 1))
                begin
                    row_next = row_reg + ROW_BITS'(1);
                end
            end
            else
            begin
                column_next = col + CW'(1);
            end
            if (flags.started)
            begin
                if (flags.last)
                begin
                    column_next = '0;
                    row_next    = '0;
                    emit_next   = '0;
                    ox_next     = '0;
                    oy_next     = '0;
                end
                else
                begin
                    emit_next = emit_reg + TB'(1);
                    if ((ox_reg + WB'(1)) >= w_eff)
                    begin
                        ox_next = '0;
                        oy_next = oy_reg + TB'(1);
                    end
                    else
                    begin
                        ox_next = ox_reg + WB'(1);
                    end
                end
            end
        end
    end

    // configuration registers and counter state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= CFG_BITS'(640);
            frame_height_reg <= CFG_BITS'(480);
            border_width_reg <= BORDER_BITS'(1);
            total_reg        <= TB'(640 * 480);
            cfg_pend_reg     <= 1'b0;
            column_reg       <= '0;
            row_reg          <= '0;
            emit_reg         <= '0;
            ox_reg           <= '0;
            oy_reg           <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_FRAME_WIDTH:  frame_width_reg  <= cfg_data;
                    REG_FRAME_HEIGHT: frame_height_reg <= cfg_data;
                    REG_BORDER_WIDTH: border_width_reg <= cfg_data[BORDER_BITS-1:0];
                    default:          ;
                endcase
            end
            cfg_pend_reg <= cfg_we;
            total_reg    <= TB'(w_eff) * TB'(h_eff);
            column_reg   <= column_next;
            row_reg      <= row_next;
            emit_reg     <= emit_next;
            ox_reg       <= ox_next;
            oy_reg       <= oy_next;
        end
    end

    `ENMS_ASSERT_IMPL(a_busy_holds_input, clk, rst_n, busy, !in_ready)
    `ENMS_ASSERT_NEXT(a_frame_wraps, clk, rst_n, issue && flags.started && flags.last, (emit_reg == '0) && (row_reg == '0) && (column_reg == '0))
    `ENMS_ASSERT_IMPL(a_ox_in_row, clk, rst_n, !busy, ox_reg < w_eff)

endmodule

`default_nettype wire

@@ rtl/core/enms_core.sv @@
// enms_core: line buffers, 3x3 window, direction compare and result register
// depends on enms_pkg, enms_if, enms_ram and edge_non_max_suppression_defines.svh
`default_nettype none
`include "edge_non_max_suppression_defines.svh"

module enms_core #(
    parameter int MAX_WIDTH = enms_pkg::MAX_WIDTH_DEF,
    parameter int MAG_BITS  = enms_pkg::MAG_BITS_DEF
) (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   issue,
    input  wire logic                                   drain,
    input  wire logic [$clog2(MAX_WIDTH)-1:0]           addr,
    input  wire enms_pkg::enms_flags_t                  flags,
    input  wire logic [MAG_BITS-1:0]                    magnitude,
    input  wire logic signed [enms_pkg::ANG_BITS-1:0]   angle,
    output logic                                        s2_free,
    enms_res_if.source                                  results
);
    import enms_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = 2 * MAG_BITS + 2;

    logic                s2_valid_reg;
    logic [MAG_BITS-1:0] s2_mag_reg;
    enms_sector_t        s2_sec_reg;
    logic [CW-1:0]       s2_addr_reg;
    enms_flags_t         s2_flags_reg;
    logic                fwd_reg;
    logic [RW-1:0]       fwd_data_reg;
    logic [MAG_BITS-1:0] win1_reg [3];
    logic [MAG_BITS-1:0] win2_reg [3];
    enms_sector_t        centre_sec_reg;
    logic                out_valid_reg;
    logic [MAG_BITS-1:0] out_value_reg;
    logic                out_sup_reg;
    logic                out_last_reg;

    logic [RW-1:0]       ram_q;
    logic [RW-1:0]       rd_word;
    logic [RW-1:0]       wr_word;
    logic [MAG_BITS-1:0] rd2;
    logic [MAG_BITS-1:0] rd1;
    enms_sector_t        rd_sec;
    logic [MAG_BITS-1:0] centre;
    logic [MAG_BITS-1:0] n1;
    logic [MAG_BITS-1:0] n2;
    logic                sup;
    logic                s2_go;

    // line buffer word: two rows above, row above, direction of row above
    enms_ram #(
        .WIDTH (RW),
        .DEPTH (MAX_WIDTH)
    ) u_lines (
        .clk   (clk),
        .we    (s2_go),
        .waddr (s2_addr_reg),
        .wdata (wr_word),
        .re    (issue),
        .raddr (addr),
        .rdata (ram_q)
    );

    // bypass a write to the column that was read in the same cycle
    assign rd_word = fwd_reg ? fwd_data_reg : ram_q;
    assign rd2     = rd_word[RW-1 -: MAG_BITS];
    assign rd1     = rd_word[MAG_BITS+1 -: MAG_BITS];
    assign rd_sec  = enms_sector_t'(rd_word[1:0]);
    assign wr_word = {rd1, s2_mag_reg, s2_sec_reg};

    // stage advance: items with no result never wait for the output
    assign s2_go   = s2_valid_reg
                     && (!s2_flags_reg.started || !out_valid_reg || results.ready);
    assign s2_free = !s2_valid_reg || s2_go;

    // neighbours along the gradient direction in the shifted window
    assign centre = win2_reg[1];
    always_comb
    begin
        n1 = win1_reg[1];
        n2 = rd1;
        case (centre_sec_reg)
            SEC_HORIZ:
            begin
                n1 = win1_reg[1];
                n2 = rd1;
            end
            SEC_DIAG:
            begin
                n1 = win1_reg[0];
                n2 = s2_mag_reg;
            end
            SEC_VERT:
            begin
                n1 = win2_reg[0];
                n2 = win2_reg[2];
            end
            SEC_ANTI:
            begin
                n1 = win1_reg[2];
                n2 = rd2;
            end
        endcase
    end
    assign sup = !s2_flags_reg.border && ((centre < n1) || (centre < n2));

    // pixel stage control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
            fwd_reg      <= 1'b0;
        end
        else if (issue)
        begin
            s2_valid_reg <= 1'b1;
            fwd_reg      <= s2_go && (s2_addr_reg == addr);
        end
        else if (s2_go)
        begin
            s2_valid_reg <= 1'b0;
        end
    end

    // pixel stage payload
    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            s2_mag_reg   <= drain ? '0 : magnitude;
            s2_sec_reg   <= drain ? SEC_HORIZ : quantize_angle(angle);
            s2_addr_reg  <= addr;
            s2_flags_reg <= flags;
            fwd_data_reg <= wr_word;
        end
    end

    // 3x3 window columns and centre direction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win1_reg       <= '{default: '0};
            win2_reg       <= '{default: '0};
            centre_sec_reg <= SEC_HORIZ;
        end
        else if (s2_go)
        begin
            win1_reg       <= win2_reg;
            win2_reg       <= '{rd2, rd1, s2_mag_reg};
            centre_sec_reg <= rd_sec;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s2_go && s2_flags_reg.started)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (results.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_go && s2_flags_reg.started)
        begin
            out_value_reg <= sup ? '0 : centre;
            out_sup_reg   <= sup;
            out_last_reg  <= s2_flags_reg.last;
        end
    end

    assign results.valid         = out_valid_reg;
    assign results.edge_value    = out_value_reg;
    assign results.suppressed    = out_sup_reg;
    assign results.last_of_frame = out_last_reg;

    `ENMS_ASSERT_IMPL(a_sup_is_zero, clk, rst_n, out_valid_reg && out_sup_reg, out_value_reg == '0)
    `ENMS_ASSERT_NEXT(a_bypass_taken, clk, rst_n, issue && s2_go && (addr == s2_addr_reg), fwd_reg)
    `ENMS_ASSERT_IMPL(a_no_result_overwrite, clk, rst_n, out_valid_reg && !results.ready, !(s2_go && s2_flags_reg.started))

endmodule

`default_nettype wire

@@ rtl/core/edge_non_max_suppression.sv @@
// edge_non_max_suppression: top level of the streaming non-max suppression block
// depends on enms_pkg, enms_if, enms_ctrl and enms_core
//
// Usage:
//   pixels carries one transaction per pixel in raster order (command 0) or a
//   flush (command 1); results carries at most one transaction per pixel
//   transaction. Both channels use valid/ready, a transaction moves on a clock
//   edge where both are high. The configuration port writes frame width,
//   frame height and border width by index whenever cfg_we is high.
//   Throughput is one pixel transaction per cycle while ready stays high. The
//   result for a pixel passes the pixel stage and the result register after
//   the transaction one row plus one pixel later that completes its 3x3
//   window; flush transactions drain the final row plus one pixel. Flushes
//   that arrive mid-frame are taken and dropped. After each configuration
//   write the pixel channel holds ready low while the serial divider rebuilds
//   the output column and row from the result count. Reset loads the 640x480,
//   border 1 geometry and clears all counters and the window. A stalled result
//   receiver holds the result register; the pixel stage behind it can still
//   take one more transaction before ready drops.
`default_nettype none

module edge_non_max_suppression #(
    parameter int MAX_WIDTH = enms_pkg::MAX_WIDTH_DEF,
    parameter int MAG_BITS  = enms_pkg::MAG_BITS_DEF
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_we,
    input  wire logic [enms_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  wire logic [enms_pkg::CFG_BITS-1:0]      cfg_data,
    enms_pix_if.sink                                pixels,
    enms_res_if.source                              results
);
    import enms_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);

    logic          in_ready;
    logic          issue;
    logic          drain;
    logic          s2_free;
    logic [CW-1:0] addr;
    enms_flags_t   flags;

    // counters, configuration and per-transaction decisions
    enms_ctrl #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (pixels.valid),
        .in_command (pixels.command),
        .s2_free    (s2_free),
        .in_ready   (in_ready),
        .issue      (issue),
        .drain      (drain),
        .addr       (addr),
        .flags      (flags)
    );

    // line buffers, window and suppression datapath
    enms_core #(
        .MAX_WIDTH (MAX_WIDTH),
        .MAG_BITS  (MAG_BITS)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .issue     (issue),
        .drain     (drain),
        .addr      (addr),
        .flags     (flags),
        .magnitude (pixels.magnitude),
        .angle     (pixels.angle),
        .s2_free   (s2_free),
        .results   (results)
    );

    assign pixels.ready = in_ready;

endmodule

`default_nettype wire
